/* hw/rtl/pli_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

   // table geometry
   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = 5;
   localparam int DATA_W     = 32;

   // two restoring steps per cycle over a 64-bit dividend
   localparam int DIV_CYCLES = DATA_W;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   // request opcodes
   localparam logic OPCODE_WRITE = 1'b0;
   localparam logic OPCODE_QUERY = 1'b1;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_START,
      OP_EMPTY,
      OP_CLAMP,
      OP_PREV,
      OP_SETUP,
      OP_MUL,
      OP_DIV,
      OP_FIN
   } dp_op_type;

   typedef enum logic [2:0] {
      ADDR_HOLD,
      ADDR_ZERO,
      ADDR_ONE,
      ADDR_LAST,
      ADDR_NEXT
   } addr_sel_type;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_FIRST = 8'b0000_0010,
      ST_LAST  = 8'b0000_0100,
      ST_SCAN  = 8'b0000_1000,
      ST_MUL   = 8'b0001_0000,
      ST_DIV   = 8'b0010_0000,
      ST_FIN   = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   typedef struct packed {
      dp_op_type    op;
      addr_sel_type addr_sel;
      logic         write;
      logic         load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic n_zero;
      logic q_le_x;
      logic q_ge_x;
      logic scan_more;
      logic div_last;
   } dp_status_type;

endpackage

`default_nettype wire

/* hw/rtl/piecewise_linear_interpolator.sv */
// Write beat: accepted with no response; the block is ready again the next cycle.
// Query beat: an empty table goes straight to the done state, a query clamped at the first
// point passes the first-point check, one clamped at the last point also the last-point check,
// and an interpolating query then runs the linear breakpoint scan (one RAM read each) and the
// two-bit-per-cycle restoring division before its response is loaded. Queries run one at a time.
// Reset (synchronous, active high) clears point_count, the controller and rsp_valid.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_interpolator (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_opcode,
   input  wire logic [3:0]                req_entry_index,
   input  wire logic signed [31:0]        req_entry_x,
   input  wire logic signed [31:0]        req_entry_y,
   input  wire logic signed [31:0]        req_query_x,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [31:0]             rsp_value,
   output logic                           rsp_empty_table,
   input  wire logic                      csr_wen,
   input  wire logic [pli_pkg::CNT_W-1:0] csr_wdata
);

   pli_pkg::dp_cmd_type    cmd;
   pli_pkg::dp_status_type status;

   pli_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   pli_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_entry_index (req_entry_index),
      .req_entry_x     (req_entry_x),
      .req_entry_y     (req_entry_y),
      .req_query_x     (req_query_x),
      .csr_wen         (csr_wen),
      .csr_wdata       (csr_wdata),
      .rsp_value       (rsp_value),
      .rsp_empty_table (rsp_empty_table)
   );

endmodule

`default_nettype wire

/* hw/rtl/pli_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module pli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

/* hw/rtl/pli_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module pli_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_opcode,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire pli_pkg::dp_status_type status,
   output pli_pkg::dp_cmd_type         cmd
);

   pli_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // sequence one item through the datapath
   always_comb begin
      state_in     = state_ff;
      cmd.op       = pli_pkg::OP_NONE;
      cmd.addr_sel = pli_pkg::ADDR_HOLD;
      cmd.write    = 1'b0;
      cmd.load_out = 1'b0;
      req_ready    = 1'b0;
      case (state_ff)
         pli_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.addr_sel = pli_pkg::ADDR_ZERO;
            if (req_valid) begin
               if (req_opcode == pli_pkg::OPCODE_WRITE) begin
                  cmd.write = 1'b1;
               end else if (status.n_zero) begin
                  cmd.op   = pli_pkg::OP_EMPTY;
                  state_in = pli_pkg::ST_DONE;
               end else begin
                  cmd.op   = pli_pkg::OP_START;
                  state_in = pli_pkg::ST_FIRST;
               end
            end
         end
         pli_pkg::ST_FIRST: begin
            if (status.q_le_x) begin
               cmd.op   = pli_pkg::OP_CLAMP;
               state_in = pli_pkg::ST_DONE;
            end else begin
               cmd.op       = pli_pkg::OP_PREV;
               cmd.addr_sel = pli_pkg::ADDR_LAST;
               state_in     = pli_pkg::ST_LAST;
            end
         end
         pli_pkg::ST_LAST: begin
            if (status.q_ge_x) begin
               cmd.op   = pli_pkg::OP_CLAMP;
               state_in = pli_pkg::ST_DONE;
            end else begin
               cmd.addr_sel = pli_pkg::ADDR_ONE;
               state_in     = pli_pkg::ST_SCAN;
            end
         end
         pli_pkg::ST_SCAN: begin
            if (status.scan_more) begin
               cmd.op       = pli_pkg::OP_PREV;
               cmd.addr_sel = pli_pkg::ADDR_NEXT;
            end else begin
               cmd.op   = pli_pkg::OP_SETUP;
               state_in = pli_pkg::ST_MUL;
            end
         end
         pli_pkg::ST_MUL: begin
            cmd.op   = pli_pkg::OP_MUL;
            state_in = pli_pkg::ST_DIV;
         end
         pli_pkg::ST_DIV: begin
            cmd.op = pli_pkg::OP_DIV;
            if (status.div_last) begin
               state_in = pli_pkg::ST_FIN;
            end
         end
         pli_pkg::ST_FIN: begin
            cmd.op   = pli_pkg::OP_FIN;
            state_in = pli_pkg::ST_DONE;
         end
         pli_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = pli_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pli_pkg::ST_IDLE;
         end
      endcase
   end

   // output beat valid: set on load, drop on take
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pli_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* hw/rtl/pli_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module pli_dp (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pli_pkg::dp_cmd_type          cmd,
   output pli_pkg::dp_status_type            status,
   input  wire logic [3:0]                   req_entry_index,
   input  wire logic signed [31:0]           req_entry_x,
   input  wire logic signed [31:0]           req_entry_y,
   input  wire logic signed [31:0]           req_query_x,
   input  wire logic                         csr_wen,
   input  wire logic [pli_pkg::CNT_W-1:0]    csr_wdata,
   output logic signed [31:0]                rsp_value,
   output logic                              rsp_empty_table
);

   localparam int DW = pli_pkg::DATA_W;
   localparam int IW = pli_pkg::IDX_W;
   localparam int CW = pli_pkg::CNT_W;

   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          n_eff, n_m1;
   logic [IW-1:0]          last_idx;
   logic [IW-1:0]          addr_ff, addr_in;
   logic                   wr_en;
   logic [DW-1:0]          x_rd, y_rd;

   logic [DW-1:0]          q_ff, x_prev_ff, y_prev_ff;
   logic [DW-1:0]          a_ff, d_ff, mag_ff;
   logic                   neg_ff;
   logic [DW:0]            diff_a, diff_d, diff_y, mag_full;
   logic [2*DW-1:0]        prod;

   logic [DW-1:0]          rem_ff;
   logic [2*DW-1:0]        dd_ff;
   logic [3*DW-1:0]        step1, step2;
   logic [pli_pkg::DIV_CNT_W-1:0] div_cnt_ff;

   logic [DW:0]            sum;
   logic [DW-1:0]          res_ff, value_ff;
   logic                   res_empty_ff, empty_ff;

   // one restoring division step: shift in the next dividend bit, subtract if it fits
   function automatic logic [3*DW-1:0] div_step(input logic [DW-1:0]   rem,
                                                input logic [2*DW-1:0] dd,
                                                input logic [DW-1:0]   dv);
      logic [DW:0] t;
      logic [DW:0] diff;
      logic        qb;
      t    = {rem, dd[2*DW-1]};
      diff = t - {1'b0, dv};
      qb   = !diff[DW];
      if (qb) begin
         return {diff[DW-1:0], dd[2*DW-2:0], qb};
      end
      return {t[DW-1:0], dd[2*DW-2:0], qb};
   endfunction

   // point count register; n_eff clamps it to the table depth
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wen) begin
         count_ff <= csr_wdata;
      end
   end

   assign n_eff    = (count_ff > CW'(pli_pkg::MAX_POINTS)) ? CW'(pli_pkg::MAX_POINTS) : count_ff;
   assign n_m1     = n_eff - CW'(1);
   assign last_idx = n_m1[IW-1:0];

   // read address; the RAM output always shows the entry at addr_ff
   always_comb begin
      case (cmd.addr_sel)
         pli_pkg::ADDR_HOLD: addr_in = addr_ff;
         pli_pkg::ADDR_ZERO: addr_in = '0;
         pli_pkg::ADDR_ONE:  addr_in = IW'(1);
         pli_pkg::ADDR_LAST: addr_in = last_idx;
         pli_pkg::ADDR_NEXT: addr_in = addr_ff + IW'(1);
         default:            addr_in = addr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

   // drop writes beyond the table
   assign wr_en = cmd.write && (CW'(req_entry_index) < CW'(pli_pkg::MAX_POINTS));

   pli_ram #(.WIDTH(DW), .DEPTH(pli_pkg::MAX_POINTS)) u_x_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (req_entry_index[IW-1:0]),
      .wdata (req_entry_x),
      .raddr (addr_in),
      .rdata (x_rd)
   );

   pli_ram #(.WIDTH(DW), .DEPTH(pli_pkg::MAX_POINTS)) u_y_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (req_entry_index[IW-1:0]),
      .wdata (req_entry_y),
      .raddr (addr_in),
      .rdata (y_rd)
   );

   // segment setup: offset, span and magnitude of the ordinate step
   assign diff_a   = {q_ff[DW-1], q_ff} - {x_prev_ff[DW-1], x_prev_ff};
   assign diff_d   = {x_rd[DW-1], x_rd} - {x_prev_ff[DW-1], x_prev_ff};
   assign diff_y   = {y_rd[DW-1], y_rd} - {y_prev_ff[DW-1], y_prev_ff};
   assign mag_full = diff_y[DW] ? -diff_y : diff_y;
   assign prod     = a_ff * mag_ff;

   assign step1 = div_step(rem_ff, dd_ff, d_ff);
   assign step2 = div_step(step1[3*DW-1:2*DW], step1[2*DW-1:0], d_ff);

   // apply the signed quotient to the lower ordinate
   assign sum = neg_ff ? ({y_prev_ff[DW-1], y_prev_ff} - {1'b0, dd_ff[DW-1:0]})
                       : ({y_prev_ff[DW-1], y_prev_ff} + {1'b0, dd_ff[DW-1:0]});

   always_ff @(posedge clock) begin
      case (cmd.op)
         pli_pkg::OP_START: begin
            q_ff <= req_query_x;
         end
         pli_pkg::OP_EMPTY: begin
            res_ff       <= '0;
            res_empty_ff <= 1'b1;
         end
         pli_pkg::OP_CLAMP: begin
            res_ff       <= y_rd;
            res_empty_ff <= 1'b0;
         end
         pli_pkg::OP_PREV: begin
            x_prev_ff <= x_rd;
            y_prev_ff <= y_rd;
         end
         pli_pkg::OP_SETUP: begin
            a_ff   <= diff_a[DW-1:0];
            d_ff   <= diff_d[DW-1:0];
            mag_ff <= mag_full[DW-1:0];
            neg_ff <= diff_y[DW];
         end
         pli_pkg::OP_MUL: begin
            rem_ff <= '0;
            dd_ff  <= prod;
         end
         pli_pkg::OP_DIV: begin
            rem_ff <= step2[3*DW-1:2*DW];
            dd_ff  <= step2[2*DW-1:0];
         end
         pli_pkg::OP_FIN: begin
            res_ff       <= sum[DW-1:0];
            res_empty_ff <= 1'b0;
         end
         default: begin
         end
      endcase
      if (cmd.load_out) begin
         value_ff <= res_ff;
         empty_ff <= res_empty_ff;
      end
   end

   // division step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.op == pli_pkg::OP_MUL) begin
         div_cnt_ff <= '0;
      end else if (cmd.op == pli_pkg::OP_DIV) begin
         div_cnt_ff <= div_cnt_ff + pli_pkg::DIV_CNT_W'(1);
      end
   end

   // status back to the controller
   assign status.n_zero    = (n_eff == '0);
   assign status.q_le_x    = ($signed(q_ff) <= $signed(x_rd));
   assign status.q_ge_x    = ($signed(q_ff) >= $signed(x_rd));
   assign status.scan_more = (addr_ff < last_idx) && ($signed(x_rd) <= $signed(q_ff));
   assign status.div_last  = (div_cnt_ff == pli_pkg::DIV_CNT_W'(pli_pkg::DIV_CYCLES - 1));

   assign rsp_value       = value_ff;
   assign rsp_empty_table = empty_ff;

endmodule

`default_nettype wire

/* hw/rtl/pli_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

module pli_chk (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic                      req_opcode,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic signed [31:0]        rsp_value,
   input wire logic                      rsp_empty_table
);

   logic query_beat;

   assign query_beat = req_valid && req_ready && (req_opcode == pli_pkg::OPCODE_QUERY);

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_empty_table))
      else $error("response beat changed while stalled");

   // empty table reports zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_table |-> rsp_value == 32'sd0)
      else $error("empty table response with nonzero value");

   // reset clears the response side
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // the block is not ready in the cycle after a query beat
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      query_beat |=> !req_ready)
      else $error("request ready right after a query beat");

   // if none was pending, no response appears in the cycle after a query beat
   a_query_latency: assert property (@(posedge clock) disable iff (reset)
      query_beat && !rsp_valid |=> !rsp_valid)
      else $error("response too early after query beat");

endmodule

bind piecewise_linear_interpolator pli_chk u_pli_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_opcode      (req_opcode),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_value       (rsp_value),
   .rsp_empty_table (rsp_empty_table)
);

`default_nettype wire
